// File: sv/ppurv_pkg.sv
// Shared types and constants of the picture processor register block.
package ppurv_pkg;

  // Command codes of one input word
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_e;

  // CPU-visible register numbers
  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_e;

  // Where a read byte or the open-bus byte comes from
  typedef enum logic [1:0] {
    SRC_REG = 2'd0,
    SRC_SPR = 2'd1,
    SRC_NT  = 2'd2,
    SRC_PAT = 2'd3
  } src_e;

  localparam int unsigned SPRITE_BYTES    = 256;
  localparam int unsigned NAMETABLE_BYTES = 4096;
  localparam int unsigned PATTERN_BYTES   = 8192;
  localparam int unsigned PALETTE_BYTES   = 32;

  localparam int unsigned SprAw = $clog2(SPRITE_BYTES);
  localparam int unsigned NtAw  = $clog2(NAMETABLE_BYTES);
  localparam int unsigned PatAw = $clog2(PATTERN_BYTES);
  localparam int unsigned PalAw = $clog2(PALETTE_BYTES);

  // VRAM map boundaries on the 14-bit pointer
  localparam logic [13:0] NT_BASE  = 14'h2000;
  localparam logic [13:0] PAL_BASE = 14'h3F00;

  localparam logic [13:0] STEP_NARROW = 14'd1;
  localparam logic [13:0] STEP_WIDE   = 14'd32;

  localparam logic [7:0] STATUS_RESET = 8'hA0;
  localparam logic [7:0] STATUS_KEEP  = 8'h3F;

  localparam logic [9:0] LINE_VBLANK = 10'd241;
  localparam logic [9:0] LINE_WRAP   = 10'd262;
  localparam logic [9:0] LINE_LAST   = 10'h3FF;

  // Access request to the nametable and pattern memories
  typedef struct packed {
    logic             nt_we;
    logic             nt_re;
    logic [NtAw-1:0]  nt_addr;
    logic             pat_we;
    logic             pat_re;
    logic [PatAw-1:0] pat_addr;
    logic [7:0]       wdata;
  } vram_req_t;

endpackage

// File: sv/ppurv_if.sv
// Valid/ready channel interfaces for the command and result words.
interface ppurv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  reg_index;
  logic [7:0]  data;
  logic [12:0] pattern_addr;
  logic        warmed_up;

  modport source (output valid, cmd, reg_index, data, pattern_addr, warmed_up,
                  input ready);
  modport sink   (input valid, cmd, reg_index, data, pattern_addr, warmed_up,
                  output ready);
endinterface

interface ppurv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       nmi;

  modport source (output valid, read_data, nmi, input ready);
  modport sink   (input valid, read_data, nmi, output ready);
endinterface

// File: sv/ppu_register_and_vram_port.sv
// Top level of the picture processor register block and VRAM port.
//
// Channels: in_i carries one command word per handshake (register read,
// register write, scanline tick or pattern load); out_o returns exactly one
// result word per command: read_data (zero except for register reads) and
// nmi (set on the tick that starts vblank while ctrl bit 7 is set).
// The result word is registered, valid in the cycle after its command is taken.
// Throughput: one command per cycle unless out_o stalls. All state changes at the accepting
// edge; sprite, nametable and pattern reads come out of registered memory
// ports and are selected at the output, so one memory access per command
// sets the figure.
// Stall: while a result waits and out_o.ready is low, in_i.ready is low and
// the result holds; with out_o.ready high a new command enters each cycle.
// Reset: rst_ni clears the register file, the palette and the sprite valid
// bits at once (status reads 0xA0); no clearing pass is needed. Nametable
// and pattern memory are undefined until written. Ctrl, mask and address
// writes are dropped until a tick reports warm-up.
module ppu_register_and_vram_port (
  input  logic         clk_i,
  input  logic         rst_ni,
  ppurv_in_if.sink     in_i,
  ppurv_out_if.source  out_o
);

  ppurv_pkg::cmd_e cmd;
  ppurv_pkg::reg_e reg_sel;
  logic            accept;

  // Register file
  logic [7:0]  ctrl_q, ctrl_d, mask_q, mask_d, status_q, status_d;
  logic [7:0]  spr_idx_q, spr_idx_d, scroll_x_q, scroll_x_d, scroll_y_q, scroll_y_d;
  logic [13:0] ptr_q, ptr_d, ptr_step;
  logic [7:0]  hold_q, hold_d, latch_q, latch_d, latch_eff;
  logic        scroll_tgl_q, scroll_tgl_d, ptr_tgl_q, ptr_tgl_d, ready_q, ready_d;
  logic [9:0]  line_q, line_d, line_inc;
  ppurv_pkg::src_e latch_src_q, latch_src_d;
  logic [7:0]  pal_q [ppurv_pkg::PALETTE_BYTES];
  logic [7:0]  pal_d [ppurv_pkg::PALETTE_BYTES];

  // Sprite memory and its valid bits
  logic [7:0]                        spr_mem [ppurv_pkg::SPRITE_BYTES];
  logic [ppurv_pkg::SPRITE_BYTES-1:0] spr_vld_q;
  logic [7:0]                        spr_rdata_q, spr_byte;
  logic                              spr_rvld_q, spr_we, spr_re;

  // VRAM port
  ppurv_pkg::vram_req_t vram_req;
  logic [7:0]           nt_rdata, pat_rdata;

  // Result register
  logic            out_valid_q, out_nmi_q, out_nmi_d;
  logic [7:0]      out_byte_q, out_byte_d;
  ppurv_pkg::src_e out_src_q, out_src_d;

  assign cmd     = ppurv_pkg::cmd_e'(in_i.cmd);
  assign reg_sel = ppurv_pkg::reg_e'(in_i.reg_index);
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept  = in_i.valid && in_i.ready;

  assign ptr_step = ctrl_q[2] ? ppurv_pkg::STEP_WIDE : ppurv_pkg::STEP_NARROW;
  assign line_inc = line_q + 10'd1;
  assign spr_byte = spr_rvld_q ? spr_rdata_q : 8'h00;

  // Pick the byte behind a source tag
  function automatic logic [7:0] src_byte(ppurv_pkg::src_e src, logic [7:0] reg_byte,
                                          logic [7:0] spr_b, logic [7:0] nt_b,
                                          logic [7:0] pat_b);
    logic [7:0] res;
    case (src)
      ppurv_pkg::SRC_SPR: res = spr_b;
      ppurv_pkg::SRC_NT:  res = nt_b;
      ppurv_pkg::SRC_PAT: res = pat_b;
      default:            res = reg_byte;
    endcase
    return res;
  endfunction

  // Resolve the open-bus byte, which may still sit in a memory read register
  assign latch_eff = src_byte(latch_src_q, latch_q, spr_byte, nt_rdata, pat_rdata);

  // Decode one command word and form the next state
  always_comb begin
    ctrl_d       = ctrl_q;
    mask_d       = mask_q;
    status_d     = status_q;
    spr_idx_d    = spr_idx_q;
    scroll_x_d   = scroll_x_q;
    scroll_y_d   = scroll_y_q;
    ptr_d        = ptr_q;
    hold_d       = hold_q;
    scroll_tgl_d = scroll_tgl_q;
    ptr_tgl_d    = ptr_tgl_q;
    latch_d      = latch_q;
    latch_src_d  = latch_src_q;
    ready_d      = ready_q;
    line_d       = line_q;
    pal_d        = pal_q;
    spr_we       = 1'b0;
    spr_re       = 1'b0;
    vram_req     = '0;
    vram_req.wdata    = in_i.data;
    vram_req.nt_addr  = ptr_q[ppurv_pkg::NtAw-1:0];
    vram_req.pat_addr = ptr_q[ppurv_pkg::PatAw-1:0];
    out_byte_d   = 8'h00;
    out_src_d    = ppurv_pkg::SRC_REG;
    out_nmi_d    = 1'b0;

    if (accept) begin
      unique case (cmd)
        ppurv_pkg::CMD_READ: begin
          unique case (reg_sel)
            ppurv_pkg::REG_STATUS: begin
              out_byte_d   = status_q;
              status_d     = status_q & ppurv_pkg::STATUS_KEEP;
              latch_d      = status_q;
              latch_src_d  = ppurv_pkg::SRC_REG;
              hold_d       = 8'h00;
              scroll_tgl_d = 1'b0;
              ptr_tgl_d    = 1'b0;
            end
            ppurv_pkg::REG_OAM_DATA: begin
              spr_re      = 1'b1;
              out_src_d   = ppurv_pkg::SRC_SPR;
              latch_src_d = ppurv_pkg::SRC_SPR;
            end
            ppurv_pkg::REG_DATA: begin
              ptr_d = ptr_q + ptr_step;
              if (ptr_q < ppurv_pkg::NT_BASE) begin
                vram_req.pat_re = 1'b1;
                out_src_d       = ppurv_pkg::SRC_PAT;
                latch_src_d     = ppurv_pkg::SRC_PAT;
              end else if (ptr_q < ppurv_pkg::PAL_BASE) begin
                vram_req.nt_re = 1'b1;
                out_src_d      = ppurv_pkg::SRC_NT;
                latch_src_d    = ppurv_pkg::SRC_NT;
              end else begin
                out_byte_d  = pal_q[ptr_q[ppurv_pkg::PalAw-1:0]];
                latch_d     = 8'h00;
                latch_src_d = ppurv_pkg::SRC_REG;
              end
            end
            default: begin
              out_byte_d = latch_eff;
            end
          endcase
        end

        ppurv_pkg::CMD_WRITE: begin
          latch_d     = in_i.data;
          latch_src_d = ppurv_pkg::SRC_REG;
          unique case (reg_sel)
            ppurv_pkg::REG_CTRL: begin
              if (ready_q) ctrl_d = in_i.data;
            end
            ppurv_pkg::REG_MASK: begin
              if (ready_q) mask_d = in_i.data;
            end
            ppurv_pkg::REG_OAM_ADDR: begin
              spr_idx_d = in_i.data;
            end
            ppurv_pkg::REG_OAM_DATA: begin
              spr_we    = 1'b1;
              spr_idx_d = spr_idx_q + 8'd1;
            end
            ppurv_pkg::REG_SCROLL: begin
              if (scroll_tgl_q) scroll_y_d = in_i.data;
              else              scroll_x_d = in_i.data;
              scroll_tgl_d = !scroll_tgl_q;
            end
            ppurv_pkg::REG_ADDR: begin
              if (ready_q) begin
                if (ptr_tgl_q) ptr_d  = {hold_q[5:0], in_i.data};
                else           hold_d = in_i.data;
                ptr_tgl_d = !ptr_tgl_q;
              end
            end
            ppurv_pkg::REG_DATA: begin
              ptr_d = ptr_q + ptr_step;
              if (ptr_q >= ppurv_pkg::PAL_BASE) begin
                // Entry 0 of a half mirrors into 4, 8 and C; those three are read-only
                if (ptr_q[3:0] == 4'h0) begin
                  pal_d[{ptr_q[4], 4'h0}] = in_i.data;
                  pal_d[{ptr_q[4], 4'h4}] = in_i.data;
                  pal_d[{ptr_q[4], 4'h8}] = in_i.data;
                  pal_d[{ptr_q[4], 4'hC}] = in_i.data;
                end else if (ptr_q[3:0] != 4'h4 && ptr_q[3:0] != 4'h8 &&
                             ptr_q[3:0] != 4'hC) begin
                  pal_d[ptr_q[ppurv_pkg::PalAw-1:0]] = in_i.data;
                end
              end else if (ptr_q >= ppurv_pkg::NT_BASE) begin
                vram_req.nt_we = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end

        ppurv_pkg::CMD_TICK: begin
          if (in_i.warmed_up) ready_d = 1'b1;
          if (line_inc == ppurv_pkg::LINE_VBLANK) begin
            line_d    = line_inc;
            status_d  = {1'b1, 1'b0, status_q[5:0]};
            out_nmi_d = ctrl_q[7];
          end else if (line_inc == ppurv_pkg::LINE_WRAP) begin
            line_d   = ppurv_pkg::LINE_LAST;
            status_d = {1'b0, status_q[6:0]};
          end else begin
            line_d = line_inc;
          end
        end

        ppurv_pkg::CMD_LOAD: begin
          vram_req.pat_we   = 1'b1;
          vram_req.pat_addr = in_i.pattern_addr;
        end

        default: begin
        end
      endcase
    end
  end

  // Update the register file and palette
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q       <= 8'h00;
      mask_q       <= 8'h00;
      status_q     <= ppurv_pkg::STATUS_RESET;
      spr_idx_q    <= 8'h00;
      scroll_x_q   <= 8'h00;
      scroll_y_q   <= 8'h00;
      ptr_q        <= 14'h0000;
      hold_q       <= 8'h00;
      scroll_tgl_q <= 1'b0;
      ptr_tgl_q    <= 1'b0;
      latch_q      <= 8'h00;
      latch_src_q  <= ppurv_pkg::SRC_REG;
      ready_q      <= 1'b0;
      line_q       <= 10'd0;
      for (int i = 0; i < ppurv_pkg::PALETTE_BYTES; i++) begin
        pal_q[i] <= 8'h00;
      end
    end else begin
      ctrl_q       <= ctrl_d;
      mask_q       <= mask_d;
      status_q     <= status_d;
      spr_idx_q    <= spr_idx_d;
      scroll_x_q   <= scroll_x_d;
      scroll_y_q   <= scroll_y_d;
      ptr_q        <= ptr_d;
      hold_q       <= hold_d;
      scroll_tgl_q <= scroll_tgl_d;
      ptr_tgl_q    <= ptr_tgl_d;
      latch_q      <= latch_d;
      latch_src_q  <= latch_src_d;
      ready_q      <= ready_d;
      line_q       <= line_d;
      pal_q        <= pal_d;
    end
  end

  // Mark sprite entries once written; unwritten ones read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_vld_q <= '0;
    end else if (spr_we) begin
      spr_vld_q[spr_idx_q] <= 1'b1;
    end
  end

  // Write or read sprite memory
  always_ff @(posedge clk_i) begin
    if (spr_we) begin
      spr_mem[spr_idx_q] <= in_i.data;
    end
    if (spr_re) begin
      spr_rdata_q <= spr_mem[spr_idx_q];
      spr_rvld_q  <= spr_vld_q[spr_idx_q];
    end
  end

  ppurv_vram u_vram (
    .clk_i       (clk_i),
    .req_i       (vram_req),
    .nt_rdata_o  (nt_rdata),
    .pat_rdata_o (pat_rdata)
  );

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_byte_q <= out_byte_d;
      out_src_q  <= out_src_d;
      out_nmi_q  <= out_nmi_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = src_byte(out_src_q, out_byte_q, spr_byte, nt_rdata, pat_rdata);
  assign out_o.nmi       = out_nmi_q;

endmodule

// File: sv/ppurv_vram.sv
// Nametable and pattern memories with registered read data.
module ppurv_vram (
  input  logic                  clk_i,
  input  ppurv_pkg::vram_req_t  req_i,
  output logic [7:0]            nt_rdata_o,
  output logic [7:0]            pat_rdata_o
);

  logic [7:0] nt_mem  [ppurv_pkg::NAMETABLE_BYTES];
  logic [7:0] pat_mem [ppurv_pkg::PATTERN_BYTES];

  // Write or read the nametable store
  always_ff @(posedge clk_i) begin
    if (req_i.nt_we) begin
      nt_mem[req_i.nt_addr] <= req_i.wdata;
    end
    if (req_i.nt_re) begin
      nt_rdata_o <= nt_mem[req_i.nt_addr];
    end
  end

  // Load or read the pattern store
  always_ff @(posedge clk_i) begin
    if (req_i.pat_we) begin
      pat_mem[req_i.pat_addr] <= req_i.wdata;
    end
    if (req_i.pat_re) begin
      pat_rdata_o <= pat_mem[req_i.pat_addr];
    end
  end

endmodule

// File: sv/ppurv_checker.sv
// Port-level assertions for the register block, bound to the top level.
module ppurv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] read_data_i,
  input logic       nmi_i
);

  // Stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_data_i) && $stable(nmi_i))
    else $error("stalled result word changed");

  // Every accepted command yields a result word in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted command gave no result word");

  // An empty result slot takes a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty result slot");

  // NMI comes only from a tick, which returns no read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && nmi_i |-> read_data_i == 8'h00)
    else $error("nmi word carries read data");

endmodule

bind ppu_register_and_vram_port ppurv_checker u_ppurv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .read_data_i (out_o.read_data),
  .nmi_i       (out_o.nmi)
);

// File: tb/tb.sv
// Self-checking testbench for the picture processor register block and its VRAM port.
module tb;
  import ppurv_pkg::*;

  localparam int MAX_GAP        = 8;
  localparam int LONG_HOLD_AT   = 200;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_AT       = 300;
  localparam int RANDOM_WORDS   = 600;
  localparam int MIN_VBLANKS    = 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  localparam int VBLANK_BIT = 7;
  localparam int SPR0_BIT   = 6;
  localparam int NMI_EN_BIT = 7;
  localparam int WIDE_BIT   = 2;

  // One command word as the CPU side issues it; drain holds it back until all
  // earlier results are in.
  typedef struct packed {
    cmd_e        cmd;
    reg_e        idx;
    logic [7:0]  data;
    logic [12:0] paddr;
    logic        warm;
    logic        drain;
  } ppu_word_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       nmi;
  } ppu_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ppurv_in_if  cmd_ch ();
  ppurv_out_if res_ch ();

  logic      cmd_valid = 1'b0;
  logic      res_ready = 1'b0;
  ppu_word_t bus_word  = '0;

  assign cmd_ch.valid        = cmd_valid;
  assign cmd_ch.cmd          = bus_word.cmd;
  assign cmd_ch.reg_index    = bus_word.idx;
  assign cmd_ch.data         = bus_word.data;
  assign cmd_ch.pattern_addr = bus_word.paddr;
  assign cmd_ch.warmed_up    = bus_word.warm;
  assign res_ch.ready        = res_ready;

  ppu_register_and_vram_port u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ppu_word_t   cpu_bus_q[$];
  ppu_result_t due_results[$];
  ppu_word_t   cur_word;

  int n_planned      = 0;
  int n_cmds_taken   = 0;
  int n_results_seen = 0;
  int n_nmi_seen     = 0;
  int n_fail         = 0;
  int send_gap       = 0;
  int recv_hold      = 0;
  int idle_cycles    = 0;

  // Predicted register file and memories
  logic [7:0]  pr_ctrl, pr_mask, pr_status, pr_spr_idx, pr_scroll_x, pr_scroll_y;
  logic [7:0]  pr_hold, pr_latch;
  logic [13:0] pr_ptr;
  logic        pr_stog, pr_ptog, pr_ready;
  logic [9:0]  pr_line;
  logic [7:0]  pr_spr[SPRITE_BYTES];
  logic [7:0]  pr_nt[NAMETABLE_BYTES];
  logic [7:0]  pr_pal[PALETTE_BYTES];
  logic [7:0]  pr_pat[PATTERN_BYTES];

  // Planning view of the stimulus: enough state to keep data-port reads on
  // bytes that were written or loaded, and to count frames
  logic [13:0] g_ptr        = '0;
  logic [7:0]  g_hold       = '0;
  logic        g_ptog       = 1'b0;
  logic        g_ready      = 1'b0;
  logic        g_wide       = 1'b0;
  logic [9:0]  g_line       = '0;
  int          g_vblanks    = 0;
  logic [13:0] g_last_base  = NT_BASE;
  logic        g_drain_next = 1'b0;
  bit          nt_seen[NAMETABLE_BYTES];
  bit          pat_seen[PATTERN_BYTES];

  // Apply one accepted word to the predicted state and return its result word
  function automatic ppu_result_t ppu_exec(ppu_word_t w);
    ppu_result_t r;
    logic [13:0] step;
    r = '0;
    step = pr_ctrl[WIDE_BIT] ? STEP_WIDE : STEP_NARROW;
    case (w.cmd)
      CMD_READ: begin
        case (w.idx)
          REG_STATUS: begin
            r.rd = pr_status;
            pr_status = pr_status & STATUS_KEEP;
            pr_latch = r.rd;
            pr_hold = '0;
            pr_stog = 1'b0;
            pr_ptog = 1'b0;
          end
          REG_OAM_DATA: begin
            r.rd = pr_spr[pr_spr_idx];
            pr_latch = r.rd;
          end
          REG_DATA: begin
            if (pr_ptr < NT_BASE) r.rd = pr_pat[pr_ptr[12:0]];
            else if (pr_ptr < PAL_BASE) r.rd = pr_nt[pr_ptr[11:0]];
            else r.rd = pr_pal[pr_ptr[4:0]];
            pr_latch = (pr_ptr < PAL_BASE) ? r.rd : 8'h00;
            pr_ptr = pr_ptr + step;
          end
          default: r.rd = pr_latch;
        endcase
      end
      CMD_WRITE: begin
        pr_latch = w.data;
        case (w.idx)
          REG_CTRL: if (pr_ready) pr_ctrl = w.data;
          REG_MASK: if (pr_ready) pr_mask = w.data;
          REG_OAM_ADDR: pr_spr_idx = w.data;
          REG_OAM_DATA: begin
            pr_spr[pr_spr_idx] = w.data;
            pr_spr_idx = pr_spr_idx + 8'd1;
          end
          REG_SCROLL: begin
            if (pr_stog) pr_scroll_y = w.data;
            else pr_scroll_x = w.data;
            pr_stog = !pr_stog;
          end
          REG_ADDR: begin
            if (pr_ready) begin
              if (pr_ptog) pr_ptr = {pr_hold[5:0], w.data};
              else pr_hold = w.data;
              pr_ptog = !pr_ptog;
            end
          end
          REG_DATA: begin
            // Pattern space is read-only; palette entry 0 of a half fans out
            // to entries 0, 4, 8 and C, which are otherwise locked
            if (pr_ptr >= PAL_BASE) begin
              if (pr_ptr[3:0] == 4'h0) begin
                for (int k = 0; k < 4; k++) pr_pal[{pr_ptr[4], 2'(k), 2'b00}] = w.data;
              end else if (pr_ptr[1:0] != 2'b00) begin
                pr_pal[pr_ptr[4:0]] = w.data;
              end
            end else if (pr_ptr >= NT_BASE) begin
              pr_nt[pr_ptr[11:0]] = w.data;
            end
            pr_ptr = pr_ptr + step;
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (w.warm) pr_ready = 1'b1;
        pr_line = pr_line + 10'd1;
        if (pr_line == LINE_VBLANK) begin
          pr_status[VBLANK_BIT] = 1'b1;
          pr_status[SPR0_BIT] = 1'b0;
          r.nmi = pr_ctrl[NMI_EN_BIT];
        end else if (pr_line == LINE_WRAP) begin
          pr_line = LINE_LAST;
          pr_status[VBLANK_BIT] = 1'b0;
        end
      end
      default: pr_pat[w.paddr] = w.data;
    endcase
    return r;
  endfunction

  function automatic ppu_word_t word_of(cmd_e c, reg_e r, logic [7:0] d);
    ppu_word_t w;
    w.cmd   = c;
    w.idx   = r;
    w.data  = d;
    w.paddr = 13'($urandom);
    w.warm  = 1'($urandom);
    w.drain = 1'b0;
    return w;
  endfunction

  // Track the planning state and queue the word; a data read that would
  // land on a never-written byte becomes a data write instead
  function automatic void queue_word(ppu_word_t w);
    logic [13:0] step;
    logic        known;
    step = g_wide ? STEP_WIDE : STEP_NARROW;
    if (g_ptr < NT_BASE) known = pat_seen[g_ptr[12:0]];
    else if (g_ptr < PAL_BASE) known = nt_seen[g_ptr[11:0]];
    else known = 1'b1;
    if (w.cmd == CMD_READ && w.idx == REG_DATA && !known) w.cmd = CMD_WRITE;
    w.drain = g_drain_next;
    g_drain_next = 1'b0;
    case (w.cmd)
      CMD_READ: begin
        if (w.idx == REG_STATUS) begin
          g_ptog = 1'b0;
          g_hold = '0;
        end else if (w.idx == REG_DATA) begin
          g_ptr = g_ptr + step;
        end
      end
      CMD_WRITE: begin
        if (w.idx == REG_CTRL && g_ready) g_wide = w.data[WIDE_BIT];
        if (w.idx == REG_ADDR && g_ready) begin
          if (g_ptog) g_ptr = {g_hold[5:0], w.data};
          else g_hold = w.data;
          g_ptog = !g_ptog;
        end
        if (w.idx == REG_DATA) begin
          if (g_ptr >= NT_BASE && g_ptr < PAL_BASE) nt_seen[g_ptr[11:0]] = 1'b1;
          g_ptr = g_ptr + step;
        end
      end
      CMD_TICK: begin
        if (w.warm) g_ready = 1'b1;
        g_line = g_line + 10'd1;
        if (g_line == LINE_VBLANK) g_vblanks++;
        else if (g_line == LINE_WRAP) g_line = LINE_LAST;
      end
      default: pat_seen[w.paddr] = 1'b1;
    endcase
    cpu_bus_q.push_back(w);
    n_planned++;
  endfunction

  function automatic void put(cmd_e c, reg_e r, logic [7:0] d);
    queue_word(word_of(c, r, d));
  endfunction

  // Load the two-write address register, usually after a status read that
  // realigns the write toggle
  function automatic void aim_pointer(logic [13:0] tgt);
    if ($urandom_range(0, 3) != 0) put(CMD_READ, REG_STATUS, 8'($urandom));
    put(CMD_WRITE, REG_ADDR, {2'($urandom), tgt[13:8]});
    put(CMD_WRITE, REG_ADDR, tgt[7:0]);
  endfunction

  // Plan one random burst of CPU activity
  function automatic void plan_burst();
    int          pick;
    int          n;
    logic [13:0] tgt;
    logic [7:0]  d;
    ppu_word_t   w;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n = $urandom_range(1, 40);
      repeat (n) put(CMD_TICK, reg_e'($urandom_range(0, 7)), 8'($urandom));
    end else if (pick < 42) begin
      case ($urandom_range(0, 3))
        0, 1: tgt = g_last_base;
        2: tgt = 14'($urandom_range(NT_BASE, PAL_BASE - 1));
        default: tgt = PAL_BASE | 14'($urandom_range(0, 255));
      endcase
      g_last_base = tgt;
      aim_pointer(tgt);
    end else if (pick < 56) begin
      n = $urandom_range(1, 8);
      repeat (n) put(CMD_WRITE, REG_DATA, 8'($urandom));
    end else if (pick < 66) begin
      n = $urandom_range(1, 6);
      repeat (n) put(CMD_READ, REG_DATA, 8'($urandom));
    end else if (pick < 74) begin
      d = 8'($urandom);
      if ($urandom_range(0, 3) != 0) d[NMI_EN_BIT] = 1'b1;
      put(CMD_WRITE, ($urandom_range(0, 2) != 0) ? REG_CTRL : REG_MASK, d);
    end else if (pick < 82) begin
      put(CMD_WRITE, REG_OAM_ADDR, 8'($urandom));
      n = $urandom_range(1, 6);
      repeat (n) put($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, REG_OAM_DATA, 8'($urandom));
    end else if (pick < 88) begin
      put(CMD_WRITE, REG_SCROLL, 8'($urandom));
      put(CMD_WRITE, REG_SCROLL, 8'($urandom));
      put(CMD_READ, reg_e'($urandom_range(0, 6)), 8'($urandom));
      put(CMD_WRITE, REG_STATUS, 8'($urandom));
    end else if (pick < 94) begin
      // fill a few pattern bytes at the current stride, then read them back
      tgt = {1'b0, 13'($urandom)};
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
        w = word_of(CMD_LOAD, reg_e'($urandom_range(0, 7)), 8'($urandom));
        w.paddr = tgt[12:0] + 13'(k * (g_wide ? 32 : 1));
        queue_word(w);
      end
      aim_pointer(tgt);
      repeat (n) put(CMD_READ, REG_DATA, 8'($urandom));
    end else begin
      put(cmd_e'($urandom_range(0, 3)), reg_e'($urandom_range(0, 7)), 8'($urandom));
    end
  endfunction

  // Offer queued words, with a random gap after each accepted one
  always @(posedge clk_i or negedge rst_ni) begin : p_drive
    logic offer;
    if (!rst_ni) begin
      cmd_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = cmd_valid;
      if (cmd_valid && cmd_ch.ready) begin
        due_results.push_back(ppu_exec(cur_word));
        n_cmds_taken++;
        offer = 1'b0;
        send_gap = ((n_cmds_taken % 128) < 32) ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cpu_bus_q.size() != 0 &&
                     !(cpu_bus_q[0].drain && due_results.size() != 0)) begin
          cur_word = cpu_bus_q.pop_front();
          offer = 1'b1;
        end
      end
      cmd_valid <= offer;
      bus_word <= cur_word;
    end
  end

  // Take result words, compare them with the oldest prediction, and stall
  always @(posedge clk_i or negedge rst_ni) begin : p_check
    ppu_result_t want;
    if (!rst_ni) begin
      res_ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (res_ch.valid && res_ready) begin
        n_results_seen++;
        if (res_ch.nmi) n_nmi_seen++;
        if (due_results.size() == 0) begin
          $error("result word with no command outstanding");
          n_fail++;
        end else begin
          want = due_results.pop_front();
          if (res_ch.read_data !== want.rd) begin
            $error("read_data: expected %02h, got %02h", want.rd, res_ch.read_data);
            n_fail++;
          end
          if (res_ch.nmi !== want.nmi) begin
            $error("nmi: expected %0b, got %0b", want.nmi, res_ch.nmi);
            n_fail++;
          end
        end
        if (n_results_seen == LONG_HOLD_AT) recv_hold = LONG_HOLD;
        else recv_hold = ((n_results_seen % 96) < 24) ? 0 : $urandom_range(0, MAX_GAP);
      end
      res_ready <= (recv_hold == 0);
      if (recv_hold > 0) recv_hold--;
    end
  end

  // Stop a run that makes no progress
  always @(posedge clk_i) begin
    if (rst_ni && !(cmd_valid && cmd_ch.ready) && !(res_ch.valid && res_ready))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : p_stim
    ppu_word_t w;
    int        n_directed;
    bit        drain_planned;

    drain_planned = 1'b0;

    // predicted state after reset
    pr_ctrl = '0; pr_mask = '0; pr_status = STATUS_RESET; pr_spr_idx = '0;
    pr_scroll_x = '0; pr_scroll_y = '0; pr_hold = '0; pr_latch = '0;
    pr_ptr = '0; pr_stog = 1'b0; pr_ptog = 1'b0; pr_ready = 1'b0; pr_line = '0;
    for (int i = 0; i < SPRITE_BYTES; i++) pr_spr[i] = '0;
    for (int i = 0; i < PALETTE_BYTES; i++) pr_pal[i] = '0;
    for (int i = 0; i < NAMETABLE_BYTES; i++) pr_nt[i] = '0;
    for (int i = 0; i < PATTERN_BYTES; i++) pr_pat[i] = '0;

    // status read and clear, writes dropped before warm-up, open bus
    put(CMD_READ, REG_STATUS, 8'h00);
    put(CMD_READ, REG_STATUS, 8'hFF);
    put(CMD_WRITE, REG_CTRL, 8'h84);
    put(CMD_WRITE, REG_ADDR, 8'hFF);
    put(CMD_READ, REG_CTRL, 8'h00);
    w = word_of(CMD_TICK, REG_CTRL, 8'h00);
    w.warm = 1'b0;
    queue_word(w);
    w.warm = 1'b1;
    queue_word(w);
    // NMI enable and wide step, palette mirror and locked entries
    put(CMD_WRITE, REG_CTRL, 8'h84);
    put(CMD_WRITE, REG_ADDR, 8'hFF);
    put(CMD_WRITE, REG_ADDR, 8'h10);
    put(CMD_WRITE, REG_DATA, 8'hFF);
    put(CMD_WRITE, REG_ADDR, 8'h3F);
    put(CMD_WRITE, REG_ADDR, 8'h14);
    put(CMD_WRITE, REG_DATA, 8'h00);
    put(CMD_WRITE, REG_ADDR, 8'h3F);
    put(CMD_WRITE, REG_ADDR, 8'h18);
    put(CMD_READ, REG_DATA, 8'h00);
    // pointer wrap from the top of palette space into pattern space
    put(CMD_WRITE, REG_CTRL, 8'h00);
    put(CMD_WRITE, REG_ADDR, 8'h3F);
    put(CMD_WRITE, REG_ADDR, 8'hFF);
    put(CMD_WRITE, REG_DATA, 8'h5A);
    w = word_of(CMD_LOAD, REG_DATA, 8'hA5);
    w.paddr = '0;
    queue_word(w);
    put(CMD_READ, REG_DATA, 8'h00);
    // sprite index wrap, read leaves the index alone
    put(CMD_WRITE, REG_OAM_ADDR, 8'hFF);
    put(CMD_WRITE, REG_OAM_DATA, 8'hFF);
    put(CMD_READ, REG_OAM_DATA, 8'h00);
    n_directed = n_planned;

    // random bursts; keep going until at least one frame reaches vblank
    while (n_planned < n_directed + RANDOM_WORDS || g_vblanks < MIN_VBLANKS) begin
      if (!drain_planned && n_planned >= n_directed + DRAIN_AT) begin
        g_drain_next  = 1'b1;
        drain_planned = 1'b1;
      end
      plan_burst();
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cpu_bus_q.size() != 0 || cmd_valid || due_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("%0d words sent (%0d directed), %0d results checked, %0d mismatches",
             n_cmds_taken, n_directed, n_results_seen, n_fail);
    $display("register, VRAM and sprite traffic over %0d vblank starts, %0d NMI pulses",
             g_vblanks, n_nmi_seen);
    if (n_fail == 0 && due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
